@@ src/mctd_pkg.sv @@
// shared constants, codes and types of the morse tree decoder
// used by every module of the block but mctd_ram; depends on nothing
`timescale 1ns / 1ps

package mctd_pkg;

	localparam int MAX_CODE_LEN = 6;
	localparam int LOAD_BITS    = 6;
	localparam int IDX_W        = MAX_CODE_LEN + 1;
	localparam int STORE_DEPTH  = 1 << IDX_W;
	localparam int DEPTH_W      = $clog2(MAX_CODE_LEN + 1);

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

	localparam logic       OP_LOAD   = 1'b0;
	localparam logic       OP_DECODE = 1'b1;
	localparam logic [1:0] SYM_DOT   = 2'd0;
	localparam logic [1:0] SYM_DASH  = 2'd1;
	localparam logic [1:0] SYM_SEP   = 2'd2;

	typedef struct packed {
		logic             is_write;
		logic [IDX_W-1:0] idx;
		logic [7:0]       letter;
		logic             miss;
	} cmd_t;

	typedef struct packed {
		logic [7:0] decoded_char;
		logic       found;
	} res_t;

endpackage

@@ src/mctd_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mctd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/mctd_front.sv @@
// front end: takes items, walks the decode path, issues store writes and lookups
// depends on mctd_pkg
`timescale 1ns / 1ps

module mctd_front import mctd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       op,
	input  logic [1:0] symbol,
	input  logic [5:0] code_bits,
	input  logic [2:0] code_length,
	input  logic [7:0] letter,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic [IDX_W-1:0]   path_index_q, path_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic               too_long_q, too_long_d;
	logic [IDX_W-1:0]   load_idx;

	always_comb begin
		load_idx = IDX_W'(1);
		for (int i = 0; i < LOAD_BITS; i++) begin
			if (i < int'(code_length)) begin
				load_idx = {load_idx[IDX_W-2:0], code_bits[i]};
			end
		end
	end

	always_comb begin
		cmd_push   = 1'b0;
		cmd        = '{is_write: 1'b0, idx: path_index_q, letter: letter, miss: too_long_q};
		path_d     = path_index_q;
		depth_d    = depth_q;
		too_long_d = too_long_q;
		case (op)
			OP_LOAD: begin
				if (!(int'(code_length) > MAX_CODE_LEN || int'(code_length) > LOAD_BITS)) begin
					cmd_push     = 1'b1;
					cmd.is_write = 1'b1;
					cmd.idx      = load_idx;
				end
			end
			OP_DECODE: begin
				if (symbol inside {SYM_DOT, SYM_DASH}) begin
					// past the deepest level the path stays put and is flagged
					if (too_long_q || depth_q >= DEPTH_W'(MAX_CODE_LEN)) begin
						too_long_d = 1'b1;
					end else begin
						path_d  = {path_index_q[IDX_W-2:0], symbol[0]};
						depth_d = depth_q + 1'b1;
					end
				end else if (symbol == SYM_SEP) begin
					// an empty token gives nothing
					cmd_push   = (depth_q != '0) || too_long_q;
					path_d     = IDX_W'(1);
					depth_d    = '0;
					too_long_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_index_q <= IDX_W'(1);
			depth_q      <= '0;
			too_long_q   <= 1'b0;
		end else if (accept) begin
			path_index_q <= path_d;
			depth_q      <= depth_d;
			too_long_q   <= too_long_d;
		end
	end

endmodule

@@ src/mctd_cmd_queue.sv @@
// short queue of store commands between front and back end
// depends on mctd_pkg
`timescale 1ns / 1ps

module mctd_cmd_queue import mctd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  cmd_t in_cmd,
	output logic full,
	output logic out_valid,
	output cmd_t out_cmd,
	input  logic pop
);

	cmd_t                entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_PTR_W:0]   count_q;
	logic                  do_push, do_pop;

	assign full      = count_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH);
	assign out_valid = count_q != '0;
	assign out_cmd   = entry_q[rd_ptr_q];
	assign do_push   = in_valid && !full;
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (CMDQ_PTR_W+1)'(do_push) - (CMDQ_PTR_W+1)'(do_pop);
		end
	end

endmodule

@@ src/mctd_back.sv @@
// back end: valid marks, letter store, lookup stage and result queue
// depends on mctd_pkg and mctd_ram
`timescale 1ns / 1ps

module mctd_back import mctd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] decoded_char,
	output logic       found
);

	logic [STORE_DEPTH-1:0] entry_valid_q;
	logic                   rd_s1, hit_s1;
	logic [7:0]             rdata;
	logic                   room, do_write, do_read;

	res_t                  res_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RESQ_PTR_W:0]   res_count_q;
	logic                  res_pop;
	res_t                  res_in;

	// a lookup goes ahead only if its result is sure of a slot
	assign room     = (res_count_q + (RESQ_PTR_W+1)'(rd_s1)) < (RESQ_PTR_W+1)'(RESQ_DEPTH);
	assign cmd_pop  = cmd_valid && (cmd.is_write || room);
	assign do_write = cmd_pop && cmd.is_write;
	assign do_read  = cmd_pop && !cmd.is_write;

	mctd_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_write),
		.waddr (cmd.idx),
		.wdata (cmd.letter),
		.re    (do_read),
		.raddr (cmd.idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			rd_s1         <= 1'b0;
		end else begin
			if (do_write) entry_valid_q[cmd.idx] <= 1'b1;
			rd_s1 <= do_read;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			hit_s1 <= !cmd.miss && entry_valid_q[cmd.idx];
		end
	end

	assign res_in.decoded_char = hit_s1 ? rdata : 8'd0;
	assign res_in.found        = hit_s1;
	assign res_pop             = pop && !empty;
	assign empty               = res_count_q == '0;
	assign decoded_char        = res_q[rd_ptr_q].decoded_char;
	assign found               = res_q[rd_ptr_q].found;

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			res_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			res_count_q <= '0;
		end else begin
			if (rd_s1)   wr_ptr_q <= wr_ptr_q + 1'b1;
			if (res_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			res_count_q <= res_count_q + (RESQ_PTR_W+1)'(rd_s1) - (RESQ_PTR_W+1)'(res_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> res_count_q < (RESQ_PTR_W+1)'(RESQ_DEPTH))
		else $error("result queue overflow");

	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> entry_valid_q[$past(cmd.idx)])
		else $error("store write left entry unmarked");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_pop && !rd_s1 |=> res_count_q == $past(res_count_q) - 1'b1)
		else $error("result transfer not counted");

endmodule

@@ src/morse_code_tree_decoder.sv @@
// top level of the morse tree decoder: front end, command queue, back end
// depends on mctd_pkg, mctd_front, mctd_cmd_queue, mctd_back
//
// channel  | handshake         | fields
// ---------+-------------------+---------------------------------------------
// input    | push / full       | op, symbol, code_bits, code_length, letter
// result   | pop / empty       | decoded_char, found
//
// one item is taken every cycle while the command queue has space
// a result goes via the command queue, the registered store read and the result queue
// the letter store is a ram with registered read; its valid marks clear at reset
// a stalled result side fills the result queue, then the command queue, then raises full
`timescale 1ns / 1ps

module morse_code_tree_decoder import mctd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       op,
	input  logic [1:0] symbol,
	input  logic [5:0] code_bits,
	input  logic [2:0] code_length,
	input  logic [7:0] letter,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] decoded_char,
	output logic       found
);

	logic accept;
	logic front_push, cmd_valid, cmd_pop;
	cmd_t front_cmd, head_cmd;

	assign accept = push && !full;

	mctd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (op),
		.symbol      (symbol),
		.code_bits   (code_bits),
		.code_length (code_length),
		.letter      (letter),
		.cmd_push    (front_push),
		.cmd         (front_cmd)
	);

	mctd_cmd_queue u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept && front_push),
		.in_cmd    (front_cmd),
		.full      (full),
		.out_valid (cmd_valid),
		.out_cmd   (head_cmd),
		.pop       (cmd_pop)
	);

	mctd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (head_cmd),
		.cmd_pop      (cmd_pop),
		.empty        (empty),
		.pop          (pop),
		.decoded_char (decoded_char),
		.found        (found)
	);

endmodule
